/* sv/mmbg_pkg.sv */
// ----------------------------------------------------------------------------
// mmbg_pkg
// Shared constants, codes and types of the min/max background model.
// ----------------------------------------------------------------------------
package mmbg_pkg;

  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 512;
  localparam int unsigned SAMPLE_BITS = 8;

  localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned X_W        = 10;
  localparam int unsigned Y_W        = 9;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned COLS_W     = 11;
  localparam int unsigned ROWS_W     = 10;
  localparam int unsigned LRAT_W     = 8;
  localparam int unsigned HRAT_W     = 9;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PROD_W     = VAL_W + HRAT_W;

  localparam logic [VAL_W-1:0] SAMPLE_MAX = VAL_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [COLS_W-1:0] COLS_LIMIT = COLS_W'(MAX_COLS);
  localparam logic [ROWS_W-1:0] ROWS_LIMIT = ROWS_W'(MAX_ROWS);
  localparam logic [PROD_W-1:0] PCT_SCALE  = PROD_W'(100);

  localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(640);
  localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(480);
  localparam logic [LRAT_W-1:0] LRAT_RST = LRAT_W'(70);
  localparam logic [HRAT_W-1:0] HRAT_RST = HRAT_W'(130);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LRAT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HRAT = CFG_IDX_W'(4);

  typedef enum logic [MODE_W-1:0] {
    MODE_TRAIN  = 2'd0,
    MODE_MASK   = 2'd1,
    MODE_DETECT = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef struct packed {
    logic             trained;
    logic             masked;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
  } entry_t;

  typedef struct packed {
    logic [VAL_W-1:0] display_value;
    logic             in_mask;
    logic             changed;
    logic             bad_coordinate;
  } result_t;

  typedef struct packed {
    mode_e             mode;
    logic [LRAT_W-1:0] low_ratio_pct;
    logic [HRAT_W-1:0] high_ratio_pct;
  } cfg_t;

endpackage

/* sv/mmbg_addr.sv */
// ----------------------------------------------------------------------------
// mmbg_addr
// Frame bound check and store address of an incoming pixel.
// ----------------------------------------------------------------------------
module mmbg_addr (
  input  logic [mmbg_pkg::COLS_W-1:0] frame_cols_i,
  input  logic [mmbg_pkg::ROWS_W-1:0] frame_rows_i,
  input  logic [mmbg_pkg::X_W-1:0]    pixel_x_i,
  input  logic [mmbg_pkg::Y_W-1:0]    pixel_y_i,
  output logic [mmbg_pkg::ADDR_W-1:0] addr_o,
  output logic                        bad_o
);

  localparam int unsigned MUL_W = mmbg_pkg::Y_W + mmbg_pkg::COLS_W;

  logic [mmbg_pkg::COLS_W-1:0] cols;
  logic [mmbg_pkg::ROWS_W-1:0] rows;
  logic [MUL_W-1:0]            row_base;
  logic [MUL_W:0]              sum;

  assign cols = (frame_cols_i > mmbg_pkg::COLS_LIMIT) ? mmbg_pkg::COLS_LIMIT : frame_cols_i;
  assign rows = (frame_rows_i > mmbg_pkg::ROWS_LIMIT) ? mmbg_pkg::ROWS_LIMIT : frame_rows_i;

  assign bad_o = (mmbg_pkg::COLS_W'(pixel_x_i) >= cols) ||
                 (mmbg_pkg::ROWS_W'(pixel_y_i) >= rows);

  assign row_base = MUL_W'(pixel_y_i) * MUL_W'(cols);
  assign sum      = (MUL_W + 1)'(row_base) + (MUL_W + 1)'(pixel_x_i);
  assign addr_o   = sum[mmbg_pkg::ADDR_W-1:0];

endmodule

/* sv/mmbg_rmw_store.sv */
// ----------------------------------------------------------------------------
// mmbg_rmw_store
// Pixel store: flag and bound memories, clearing sweep after reset and
// forwarding of the last write-back to a read of the same entry.
// ----------------------------------------------------------------------------
module mmbg_rmw_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [mmbg_pkg::ADDR_W-1:0] rd_addr_i,
  output mmbg_pkg::entry_t            rd_entry_o,
  input  logic                        wr_en_i,
  input  mmbg_pkg::entry_t            wr_entry_i,
  output logic                        clr_busy_o
);

  localparam int unsigned BND_W = 2 * mmbg_pkg::VAL_W;
  localparam logic [mmbg_pkg::ADDR_W-1:0] LAST_ADDR = mmbg_pkg::ADDR_W'(mmbg_pkg::STORE_DEPTH - 1);

  logic [1:0]       flag_mem  [mmbg_pkg::STORE_DEPTH];
  logic [BND_W-1:0] bound_mem [mmbg_pkg::STORE_DEPTH];

  logic [1:0]                  flag_rd_q;
  logic [BND_W-1:0]            bound_rd_q;
  logic [mmbg_pkg::ADDR_W-1:0] rd_addr_q;

  logic                        clr_busy_q;
  logic [mmbg_pkg::ADDR_W-1:0] clr_addr_q;

  logic                        last_vld_q;
  logic [mmbg_pkg::ADDR_W-1:0] last_addr_q;
  mmbg_pkg::entry_t            last_entry_q;

  logic                        flag_we;
  logic [mmbg_pkg::ADDR_W-1:0] flag_waddr;
  logic [1:0]                  flag_wdata;

  assign flag_we    = clr_busy_q || wr_en_i;
  assign flag_waddr = clr_busy_q ? clr_addr_q : rd_addr_q;
  assign flag_wdata = clr_busy_q ? 2'b00 : {wr_entry_i.trained, wr_entry_i.masked};

  // flag memory
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      flag_rd_q <= flag_mem[rd_addr_i];
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // bound memory
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      bound_rd_q <= bound_mem[rd_addr_i];
    end
    if (wr_en_i) begin
      bound_mem[rd_addr_q] <= {wr_entry_i.low, wr_entry_i.high};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_addr_q <= rd_addr_i;
    end
    if (wr_en_i) begin
      last_addr_q  <= rd_addr_q;
      last_entry_q <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      last_vld_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + mmbg_pkg::ADDR_W'(1);
        if (clr_addr_q == LAST_ADDR) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (wr_en_i) begin
        last_vld_q <= 1'b1;
      end
    end
  end

  always_comb begin
    if (last_vld_q && (last_addr_q == rd_addr_q)) begin
      rd_entry_o = last_entry_q;
    end else begin
      rd_entry_o.trained = flag_rd_q[1];
      rd_entry_o.masked  = flag_rd_q[0];
      rd_entry_o.low     = bound_rd_q[BND_W-1:mmbg_pkg::VAL_W];
      rd_entry_o.high    = bound_rd_q[mmbg_pkg::VAL_W-1:0];
    end
  end

  assign clr_busy_o = clr_busy_q;

endmodule

/* sv/mmbg_update.sv */
// ----------------------------------------------------------------------------
// mmbg_update
// Per-mode update of one store entry and the result word of the pixel.
// ----------------------------------------------------------------------------
module mmbg_update (
  input  mmbg_pkg::cfg_t             cfg_i,
  input  logic [mmbg_pkg::VAL_W-1:0] value_i,
  input  logic                       bad_i,
  input  mmbg_pkg::entry_t           entry_i,
  output mmbg_pkg::entry_t           entry_o,
  output logic                       wr_en_o,
  output mmbg_pkg::result_t          result_o
);

  localparam int unsigned PW = mmbg_pkg::PROD_W;

  logic [PW-1:0] high_scaled;
  logic [PW-1:0] low_scaled;
  logic [PW-1:0] value_low_pct;
  logic [PW-1:0] value_high_pct;
  logic          out_of_ratio;
  logic          changed;

  assign high_scaled    = PW'(entry_i.high) * mmbg_pkg::PCT_SCALE;
  assign low_scaled     = PW'(entry_i.low) * mmbg_pkg::PCT_SCALE;
  assign value_low_pct  = PW'(value_i) * PW'(cfg_i.low_ratio_pct);
  assign value_high_pct = PW'(value_i) * PW'(cfg_i.high_ratio_pct);

  assign out_of_ratio = !entry_i.trained || (high_scaled < value_low_pct) ||
                        (low_scaled > value_high_pct);

  always_comb begin
    entry_o = entry_i;
    changed = 1'b0;
    unique case (cfg_i.mode)
      mmbg_pkg::MODE_TRAIN: begin
        if (!entry_i.trained) begin
          entry_o.low  = value_i;
          entry_o.high = value_i;
        end else begin
          if (value_i < entry_i.low) begin
            entry_o.low = value_i;
          end
          if (value_i > entry_i.high) begin
            entry_o.high = value_i;
          end
        end
        entry_o.trained = 1'b1;
      end
      mmbg_pkg::MODE_MASK: begin
        entry_o.masked = entry_i.masked || out_of_ratio;
      end
      mmbg_pkg::MODE_DETECT: begin
        changed = entry_i.masked && (!entry_i.trained || (entry_i.high < value_i) ||
                                     (entry_i.low > value_i));
      end
      mmbg_pkg::MODE_CLEAR: begin
        entry_o.masked = 1'b0;
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

  assign wr_en_o = !bad_i;

  always_comb begin
    if (bad_i) begin
      result_o.display_value  = value_i;
      result_o.in_mask        = 1'b0;
      result_o.changed        = 1'b0;
      result_o.bad_coordinate = 1'b1;
    end else begin
      result_o.display_value  = ((cfg_i.mode == mmbg_pkg::MODE_MASK) && entry_o.masked) ?
                                mmbg_pkg::SAMPLE_MAX : value_i;
      result_o.in_mask        = entry_o.masked;
      result_o.changed        = changed;
      result_o.bad_coordinate = 1'b0;
    end
  end

endmodule

/* sv/minmax_background_model.sv */
// ----------------------------------------------------------------------------
// minmax_background_model
// Per-pixel min/max background model, sticky mask, a pixel per unstalled clock.
// ----------------------------------------------------------------------------
// pixel words enter on in_valid_i / in_stall_o with column, row and sample;
// one result word per pixel leaves on out_valid_o / out_stall_i
// the user writes configuration words on cfg_valid_i / cfg_ready_o while idle,
// which the block does not enforce; cfg_ready_o is always high and unknown
// register indexes are dropped; an accepted pixel is read from the store at the
// accept edge into the read registers and the update stage, updated and written
// back when the update stage fires, with the result registered at the output
// throughput: one pixel per cycle when nothing stalls, set by the single
// read-modify-write of the pixel store; a write-back is forwarded to the
// following pixel when both hit the same entry
// after reset the flag memory is swept clear one entry per cycle over the whole
// store, with in_stall_o high; configuration writes are taken meanwhile
// a stalled result holds the output register; one more pixel waits in the
// update stage, and then in_stall_o goes high until the result is taken
// ----------------------------------------------------------------------------
module minmax_background_model (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mmbg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmbg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mmbg_pkg::X_W-1:0]        pixel_x_i,
  input  logic [mmbg_pkg::Y_W-1:0]        pixel_y_i,
  input  logic [mmbg_pkg::VAL_W-1:0]      pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mmbg_pkg::VAL_W-1:0]      display_value_o,
  output logic                            in_mask_o,
  output logic                            changed_o,
  output logic                            bad_coordinate_o
);

  mmbg_pkg::mode_e             mode_q;
  logic [mmbg_pkg::COLS_W-1:0] frame_cols_q;
  logic [mmbg_pkg::ROWS_W-1:0] frame_rows_q;
  logic [mmbg_pkg::LRAT_W-1:0] low_ratio_q;
  logic [mmbg_pkg::HRAT_W-1:0] high_ratio_q;
  mmbg_pkg::cfg_t              cfg;

  logic                        upd_valid_q;
  logic [mmbg_pkg::VAL_W-1:0]  upd_value_q;
  logic                        upd_bad_q;

  logic                        out_valid_q;
  mmbg_pkg::result_t           out_res_q;

  logic                        in_accept;
  logic                        upd_fire;
  logic                        clr_busy;
  logic [mmbg_pkg::ADDR_W-1:0] rd_addr;
  logic                        in_bad;
  mmbg_pkg::entry_t            rd_entry;
  mmbg_pkg::entry_t            wr_entry;
  logic                        upd_wr_en;
  mmbg_pkg::result_t           upd_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mmbg_pkg::MODE_TRAIN;
      frame_cols_q <= mmbg_pkg::COLS_RST;
      frame_rows_q <= mmbg_pkg::ROWS_RST;
      low_ratio_q  <= mmbg_pkg::LRAT_RST;
      high_ratio_q <= mmbg_pkg::HRAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mmbg_pkg::CFG_MODE: mode_q       <= mmbg_pkg::mode_e'(cfg_data_i[mmbg_pkg::MODE_W-1:0]);
        mmbg_pkg::CFG_COLS: frame_cols_q <= cfg_data_i[mmbg_pkg::COLS_W-1:0];
        mmbg_pkg::CFG_ROWS: frame_rows_q <= cfg_data_i[mmbg_pkg::ROWS_W-1:0];
        mmbg_pkg::CFG_LRAT: low_ratio_q  <= cfg_data_i[mmbg_pkg::LRAT_W-1:0];
        mmbg_pkg::CFG_HRAT: high_ratio_q <= cfg_data_i[mmbg_pkg::HRAT_W-1:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  assign cfg.mode           = mode_q;
  assign cfg.low_ratio_pct  = low_ratio_q;
  assign cfg.high_ratio_pct = high_ratio_q;

  // pipeline handshake
  assign upd_fire   = upd_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy || (upd_valid_q && !upd_fire);
  assign in_accept  = in_valid_i && !in_stall_o;

  mmbg_addr u_addr (
    .frame_cols_i (frame_cols_q),
    .frame_rows_i (frame_rows_q),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .addr_o       (rd_addr),
    .bad_o        (in_bad)
  );

  mmbg_rmw_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (upd_fire && upd_wr_en),
    .wr_entry_i (wr_entry),
    .clr_busy_o (clr_busy)
  );

  mmbg_update u_update (
    .cfg_i    (cfg),
    .value_i  (upd_value_q),
    .bad_i    (upd_bad_q),
    .entry_i  (rd_entry),
    .entry_o  (wr_entry),
    .wr_en_o  (upd_wr_en),
    .result_o (upd_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      upd_value_q <= pixel_value_i;
      upd_bad_q   <= in_bad;
    end
    if (upd_fire) begin
      out_res_q <= upd_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        upd_valid_q <= 1'b1;
      end else if (upd_fire) begin
        upd_valid_q <= 1'b0;
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign display_value_o  = out_res_q.display_value;
  assign in_mask_o        = out_res_q.in_mask;
  assign changed_o        = out_res_q.changed;
  assign bad_coordinate_o = out_res_q.bad_coordinate;

endmodule

/* tb/sv/minmax_background_model_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minmax_background_model_tb
// Self-checking bench for the min/max background model. Pixel words go in
// with random gaps, results leave under random output stalls. A scoreboard
// keeps its own per-pixel store and registers, predicts every result word and
// checks each one field by field. Random rounds train a pixel window, build a
// mask over it, detect changes and clear points, on frames from tiny to
// oversized, with ratio extremes, out-of-frame pixels and a long output hold.
// ----------------------------------------------------------------------------
module minmax_background_model_tb;

  import mmbg_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS = 1150;
  localparam int unsigned MAX_WAIT     = 19;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned TIMEOUT_NS   = 20_000_000;

  class pixel_scoreboard;
    logic [VAL_W-1:0] low_bound[int unsigned];
    logic [VAL_W-1:0] high_bound[int unsigned];
    bit               trained_at[int unsigned];
    bit               masked_at[int unsigned];
    mode_e             mode_r;
    logic [COLS_W-1:0] cols_r;
    logic [ROWS_W-1:0] rows_r;
    logic [LRAT_W-1:0] lrat_r;
    logic [HRAT_W-1:0] hrat_r;
    result_t           expected_words[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_words;
    int unsigned       n_mode[4];
    int unsigned       n_bad;
    int unsigned       n_changed;
    int unsigned       n_masked;

    function new();
      mode_r = MODE_TRAIN;
      cols_r = COLS_RST;
      rows_r = ROWS_RST;
      lrat_r = LRAT_RST;
      hrat_r = HRAT_RST;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE: mode_r = mode_e'(data[MODE_W-1:0]);
        CFG_COLS: cols_r = data[COLS_W-1:0];
        CFG_ROWS: rows_r = data[ROWS_W-1:0];
        CFG_LRAT: lrat_r = data[LRAT_W-1:0];
        CFG_HRAT: hrat_r = data[HRAT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [VAL_W-1:0] v);
      int unsigned cols_eff;
      int unsigned rows_eff;
      int unsigned idx;
      int unsigned lo;
      int unsigned hi;
      int unsigned val;
      bit          was_trained;
      result_t     res;
      cols_eff = (cols_r < COLS_LIMIT) ? int'(cols_r) : MAX_COLS;
      rows_eff = (rows_r < ROWS_LIMIT) ? int'(rows_r) : MAX_ROWS;
      val = 32'(v);
      res.display_value  = v;
      res.in_mask        = 1'b0;
      res.changed        = 1'b0;
      res.bad_coordinate = 1'b0;
      n_words++;
      n_mode[mode_r]++;
      if (x >= cols_eff || y >= rows_eff) begin
        res.bad_coordinate = 1'b1;
        n_bad++;
      end else begin
        idx = y * cols_eff + x;
        was_trained = trained_at.exists(idx);
        lo = was_trained ? int'(low_bound[idx]) : 0;
        hi = was_trained ? int'(high_bound[idx]) : 0;
        case (mode_r)
          MODE_TRAIN: begin
            if (!was_trained) begin
              lo = val;
              hi = val;
            end
            if (val < lo) lo = val;
            if (val > hi) hi = val;
            low_bound[idx]  = VAL_W'(lo);
            high_bound[idx] = VAL_W'(hi);
            trained_at[idx] = 1'b1;
          end
          MODE_MASK: begin
            if (!was_trained || 100 * hi < val * lrat_r || 100 * lo > val * hrat_r)
              masked_at[idx] = 1'b1;
            if (masked_at.exists(idx)) begin
              res.display_value = SAMPLE_MAX;
              n_masked++;
            end
          end
          MODE_DETECT: begin
            if (masked_at.exists(idx) && (!was_trained || hi < val || lo > val)) begin
              res.changed = 1'b1;
              n_changed++;
            end
          end
          default: masked_at.delete(idx);
        endcase
        res.in_mask = masked_at.exists(idx);
      end
      expected_words.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      // only the first 40 are printed, all are counted
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %p with nothing expected", got));
      end else begin
        want = expected_words.pop_front();
        checked++;
        if (got.display_value !== want.display_value)
          report($sformatf("word %0d display_value %0d, expected %0d",
                           checked, got.display_value, want.display_value));
        if (got.in_mask !== want.in_mask)
          report($sformatf("word %0d in_mask %b, expected %b",
                           checked, got.in_mask, want.in_mask));
        if (got.changed !== want.changed)
          report($sformatf("word %0d changed %b, expected %b",
                           checked, got.changed, want.changed));
        if (got.bad_coordinate !== want.bad_coordinate)
          report($sformatf("word %0d bad_coordinate %b, expected %b",
                           checked, got.bad_coordinate, want.bad_coordinate));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_n_q = 1'b0;
  logic                  cfg_valid_q = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_q = '0;
  logic [CFG_DATA_W-1:0] cfg_data_q = '0;
  logic                  in_valid_q = 1'b0;
  logic                  in_stall_o;
  logic [X_W-1:0]        pixel_x_q = '0;
  logic [Y_W-1:0]        pixel_y_q = '0;
  logic [VAL_W-1:0]      pixel_value_q = '0;
  logic                  out_valid_o;
  logic                  out_stall_q = 1'b0;
  logic [VAL_W-1:0]      display_value_o;
  logic                  in_mask_o;
  logic                  changed_o;
  logic                  bad_coordinate_o;

  pixel_scoreboard sb = new();

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          long_hold = 1'b0;
  bit          noise = 1'b0;
  int unsigned n_holds = 0;
  int unsigned n_rounds = 0;
  int unsigned cols_eff = 640;
  int unsigned rows_eff = 480;
  int unsigned win_x0 = 0;
  int unsigned win_y0 = 0;
  int unsigned win_w = 1;
  int unsigned win_h = 1;
  int unsigned base = 128;
  int unsigned spread = 20;

  minmax_background_model i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n_q),
    .cfg_valid_i     (cfg_valid_q),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_q),
    .cfg_data_i      (cfg_data_q),
    .in_valid_i      (in_valid_q),
    .in_stall_o      (in_stall_o),
    .pixel_x_i       (pixel_x_q),
    .pixel_y_i       (pixel_y_q),
    .pixel_value_i   (pixel_value_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_q),
    .display_value_o (display_value_o),
    .in_mask_o       (in_mask_o),
    .changed_o       (changed_o),
    .bad_coordinate_o(bad_coordinate_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // register write, valid stays up until the next pixel word lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.apply_reg(idx, data);
  endtask

  task automatic send_pixel(int unsigned x, int unsigned y, int unsigned v);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    cfg_valid_q <= 1'b0;
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_q    <= 1'b1;
    pixel_x_q     <= X_W'(x);
    pixel_y_q     <= Y_W'(y);
    pixel_value_q <= VAL_W'(v);
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_pixel(X_W'(x), Y_W'(y), VAL_W'(v));
  endtask

  task automatic drain();
    in_valid_q <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // random bits above the field width now and then
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    if ($urandom_range(0, 3) != 0) junk = '0;
    return (junk << width) | CFG_DATA_W'(value);
  endfunction

  function automatic int unsigned pick_value(int unsigned widen);
    int v;
    int w;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, SAMPLE_MAX);
    w = spread + widen;
    v = int'(base) + int'($urandom_range(0, 2 * w)) - w;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
    return v;
  endfunction

  task automatic run_phase(mode_e m, int unsigned count, int unsigned widen, bit pressure);
    int unsigned x;
    int unsigned y;
    write_reg(CFG_MODE, with_junk(m, MODE_W));
    tx_quiet = pressure || ($urandom_range(0, 3) == 0);
    rx_quiet = !pressure && ($urandom_range(0, 3) == 0);
    long_hold = pressure;
    repeat (count) begin
      if (noise || cols_eff == 0 || rows_eff == 0 || $urandom_range(0, 15) == 0) begin
        x = $urandom_range(0, MAX_COLS - 1);
        y = $urandom_range(0, MAX_ROWS - 1);
      end else begin
        x = win_x0 + $urandom_range(0, win_w - 1);
        y = win_y0 + $urandom_range(0, win_h - 1);
      end
      send_pixel(x, y, pick_value(widen));
    end
    drain();
  endtask

  task automatic run_round();
    int unsigned sel;
    int unsigned cols;
    int unsigned rows;
    int unsigned lrat;
    int unsigned hrat;
    n_rounds++;
    sel = $urandom_range(0, 19);
    cols = $urandom_range(1, 16);
    rows = $urandom_range(1, 8);
    case (sel)
      0: cols = 0;
      1: rows = 0;
      2, 3, 4: begin
        cols = MAX_COLS;
        rows = MAX_ROWS;
      end
      5, 6: begin
        cols = $urandom_range(MAX_COLS + 1, (1 << COLS_W) - 1);
        rows = $urandom_range(MAX_ROWS + 1, (1 << ROWS_W) - 1);
      end
      7, 8: begin
        cols = $urandom_range(1, MAX_COLS);
        rows = $urandom_range(1, MAX_ROWS);
      end
      default: ;
    endcase
    write_reg(CFG_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_ROWS, with_junk(rows, ROWS_W));
    cols_eff = (cols < MAX_COLS) ? cols : MAX_COLS;
    rows_eff = (rows < MAX_ROWS) ? rows : MAX_ROWS;
    if (cols_eff > 0 && rows_eff > 0) begin
      win_w = $urandom_range(1, 6);
      win_h = $urandom_range(1, 4);
      if (win_w > cols_eff) win_w = cols_eff;
      if (win_h > rows_eff) win_h = rows_eff;
      win_x0 = $urandom_range(0, cols_eff - win_w);
      win_y0 = $urandom_range(0, rows_eff - win_h);
      if ($urandom_range(0, 3) == 0) begin
        win_x0 = cols_eff - win_w;
        win_y0 = rows_eff - win_h;
      end
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        lrat = $urandom_range(0, 1) ? (1 << LRAT_W) - 1 : 0;
        hrat = $urandom_range(0, 1) ? (1 << HRAT_W) - 1 : 0;
      end
      1, 2: begin
        lrat = $urandom_range(0, (1 << LRAT_W) - 1);
        hrat = $urandom_range(0, (1 << HRAT_W) - 1);
      end
      default: begin
        lrat = $urandom_range(55, 90);
        hrat = $urandom_range(110, 150);
      end
    endcase
    write_reg(CFG_LRAT, with_junk(lrat, LRAT_W));
    write_reg(CFG_HRAT, with_junk(hrat, HRAT_W));
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'(CFG_HRAT + 1 + $urandom_range(0, 2)), CFG_DATA_W'($urandom()));
    base = $urandom_range(0, SAMPLE_MAX);
    spread = $urandom_range(0, 40);
    noise = (n_rounds % 6 != 2) && ($urandom_range(0, 6) == 0);
    if (noise) begin
      repeat (3) run_phase(mode_e'($urandom_range(0, 3)), $urandom_range(5, 20), 0, 1'b0);
    end else begin
      run_phase(MODE_TRAIN, $urandom_range(10, 40), 0, n_rounds % 6 == 2);
      run_phase(MODE_MASK, $urandom_range(8, 25), 30, 1'b0);
      run_phase(MODE_DETECT, $urandom_range(8, 25), 40, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
        run_phase(MODE_CLEAR, $urandom_range(2, 8), 0, 1'b0);
        run_phase(MODE_DETECT, $urandom_range(4, 12), 40, 1'b0);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    result_t     got;
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
        n_holds++;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold > 0) begin
        out_stall_q <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_q <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{display_value_o, in_mask_o, changed_o, bad_coordinate_o};
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned directed_words;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n_q <= 1'b1;
    @(posedge clk_i);

    // untrained pixel: masked on sight, then reported as changed, then cleared
    write_reg(CFG_COLS, COLS_RST);
    write_reg(CFG_ROWS, CFG_DATA_W'(ROWS_RST));
    write_reg(CFG_LRAT, CFG_DATA_W'(LRAT_RST));
    write_reg(CFG_HRAT, CFG_DATA_W'(HRAT_RST));
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_MASK));
    send_pixel(0, 0, 37);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DETECT));
    send_pixel(0, 0, 0);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_CLEAR));
    send_pixel(0, 0, SAMPLE_MAX);
    drain();

    // seed, then widen both ways; back-to-back words on one entry
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_TRAIN));
    tx_quiet = 1'b1;
    send_pixel(0, 0, 100);
    send_pixel(0, 0, 90);
    send_pixel(0, 0, 120);
    send_pixel(1, 0, 100);
    send_pixel(COLS_RST - 1, ROWS_RST - 1, SAMPLE_MAX);
    send_pixel(COLS_RST - 1, ROWS_RST - 1, 0);
    tx_quiet = 1'b0;
    drain();

    // mask above the range, inside it, below it
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_MASK));
    send_pixel(0, 0, 200);
    send_pixel(1, 0, 100);
    send_pixel(1, 0, 70);
    send_pixel(COLS_RST - 1, ROWS_RST - 1, 128);
    drain();

    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DETECT));
    send_pixel(0, 0, 121);
    send_pixel(0, 0, 100);
    send_pixel(COLS_RST - 1, ROWS_RST - 1, 5);
    send_pixel(COLS_RST, 0, 1);
    send_pixel(0, ROWS_RST, 2);
    drain();

    // oversized frame clamps to the store, far corner trained
    write_reg(CFG_COLS, CFG_DATA_W'((1 << COLS_W) - 1));
    write_reg(CFG_ROWS, CFG_DATA_W'((1 << ROWS_W) - 1));
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_TRAIN));
    send_pixel(MAX_COLS - 1, MAX_ROWS - 1, SAMPLE_MAX);
    send_pixel(MAX_COLS - 1, MAX_ROWS - 1, 0);
    drain();

    // zero width frame rejects everything
    write_reg(CFG_COLS, CFG_DATA_W'(0));
    send_pixel(0, 0, 9);
    drain();
    directed_words = sb.n_words;

    while (sb.n_words < directed_words + RANDOM_WORDS) run_round();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d pixel words in %0d rounds: %0d train, %0d mask, %0d detect, %0d clear",
             sb.n_words, n_rounds, sb.n_mode[MODE_TRAIN], sb.n_mode[MODE_MASK],
             sb.n_mode[MODE_DETECT], sb.n_mode[MODE_CLEAR]);
    $display("%0d out of frame, %0d shown masked, %0d changed, %0d long output holds",
             sb.n_bad, sb.n_masked, sb.n_changed, n_holds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
